>>> hw/rtl/lwe_dec_pkg.sv
// shared types and constants for the lwe decryption block
package lwe_dec_pkg;

   localparam int KEY_LENGTH_DEF = 1024;
   localparam int MOD_WIDTH_DEF  = 32;

   localparam int SCALE_BITS = 16;
   localparam int QUO_W      = SCALE_BITS + 1;

   localparam logic [31:0] CIPHER_MOD_RESET = 32'd1024;
   localparam logic [15:0] PLAIN_MOD_RESET  = 16'd4;

   typedef enum logic {
      REG_CIPHER_MOD = 1'b0,
      REG_PLAIN_MOD  = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      CMD_KEY  = 2'd0,
      CMD_A    = 2'd1,
      CMD_B    = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ASEL_ONE,
      ASEL_RES,
      ASEL_DIFF
   } a_sel_type;

   typedef enum logic [1:0] {
      BSEL_VAL,
      BSEL_KEY,
      BSEL_INNER,
      BSEL_PLAIN
   } b_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_VAL_INIT,
      ST_VAL_RUN,
      ST_MUL_INIT,
      ST_MUL_RUN,
      ST_INNER_INIT,
      ST_INNER_RUN,
      ST_ACC,
      ST_SCALE_INIT,
      ST_SCALE_RUN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic      start;
      a_sel_type a_sel;
      b_sel_type b_sel;
      logic      step;
      logic      save_x;
      logic      acc_upd;
      logic      finish;
   } dp_ctl_type;

endpackage

>>> hw/rtl/lwe_decrypt.sv
// lwe decryption top level: config registers, controller and datapath
// key write and ignored requests: accepted every cycle while idle, no result
// a element: the next request waits until it completes, bound by one
//   bit-serial modular step unit doing reduce, multiply and accumulator reduce in turn
// b element: result valid after reduce, inner sum reduce and scaling on the same unit
// reset clears control, inner sum to zero, moduli to 1024 and 4; key store is not cleared
module lwe_decrypt
   import lwe_dec_pkg::*;
#(
   parameter int KEY_LENGTH = KEY_LENGTH_DEF,
   parameter int MOD_WIDTH  = MOD_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // index[9:0], value[41:10], zero pad
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // message[15:0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [31:0]   cipher_mod_ff;
   logic [15:0]   plain_mod_ff;
   logic          csr_write;
   reg_index_type csr_reg;
   logic          accept;
   dp_ctl_type    ctl;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cipher_mod_ff <= CIPHER_MOD_RESET;
         plain_mod_ff  <= PLAIN_MOD_RESET;
      end else if (csr_write) begin
         unique case (csr_reg)
            REG_CIPHER_MOD: cipher_mod_ff <= csr_pwdata;
            REG_PLAIN_MOD:  plain_mod_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         REG_CIPHER_MOD: csr_prdata = cipher_mod_ff;
         REG_PLAIN_MOD:  csr_prdata = 32'(plain_mod_ff);
         default:        csr_prdata = '0;
      endcase
   end

   lwe_dec_ctrl #(
      .MOD_WIDTH (MOD_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tuser),
      .rsp_tready (rsp_tready),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .accept     (accept),
      .ctl        (ctl)
   );

   lwe_dec_dp #(
      .KEY_LENGTH (KEY_LENGTH),
      .MOD_WIDTH  (MOD_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_cmd        (req_tuser),
      .req_index      (req_tdata[9:0]),
      .req_value      (req_tdata[41:10]),
      .cipher_modulus (cipher_mod_ff),
      .plain_modulus  (plain_mod_ff),
      .ctl            (ctl),
      .message        (rsp_tdata)
   );

endmodule

>>> hw/rtl/lwe_dec_dp.sv
// datapath: key store, bit-serial modular step unit, accumulator and result register
module lwe_dec_dp
   import lwe_dec_pkg::*;
#(
   parameter int KEY_LENGTH = KEY_LENGTH_DEF,
   parameter int MOD_WIDTH  = MOD_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [1:0]       req_cmd,
   input  logic [9:0]       req_index,
   input  logic [31:0]      req_value,
   input  logic [31:0]      cipher_modulus,
   input  logic [15:0]      plain_modulus,
   input  dp_ctl_type       ctl,
   output logic [15:0]      message
);

   localparam int W   = MOD_WIDTH;
   localparam int BW  = (MOD_WIDTH > SCALE_BITS) ? MOD_WIDTH : SCALE_BITS;
   localparam int KAW = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;

   logic [W-1:0]     key_mem [KEY_LENGTH];
   logic [W-1:0]     key_rd_ff;
   logic             key_ok_ff;
   logic [W-1:0]     val_ff;
   logic [W-1:0]     inner_ff;
   logic [W-1:0]     inner_in;
   logic [W-1:0]     r_ff;
   logic [W-1:0]     r_in;
   logic [W-1:0]     a_ff;
   logic [W-1:0]     a_in;
   logic [BW-1:0]    b_ff;
   logic [BW-1:0]    b_in;
   logic [W-1:0]     x_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [QUO_W-1:0] quo_in;
   logic [15:0]      msg_ff;
   logic [15:0]      msg_in;

   logic [63:0]      val_ext;
   logic [63:0]      q_ext;
   logic [31:0]      idx_ext;
   logic [W-1:0]     q_w;
   logic [W:0]       qx;
   logic             qsmall;
   logic             key_hit;
   logic [KAW-1:0]   addr;
   logic [W-1:0]     b_src;
   logic [W-1:0]     diff;
   logic [W:0]       r2;
   logic [W:0]       r3;
   logic [W:0]       r4;
   logic [W:0]       r5;
   logic             c1;
   logic             c2;
   logic             bit_now;
   logic [W:0]       acc_sum;
   logic [W:0]       acc_mod;
   logic             round_up;
   logic [QUO_W-1:0] quo_rnd;

   assign val_ext = 64'(req_value);
   assign q_ext   = 64'(cipher_modulus);
   assign idx_ext = 32'(req_index);
   assign q_w     = q_ext[W-1:0];
   assign qx      = {1'b0, q_w};
   assign qsmall  = (q_w < W'(2));
   assign key_hit = (idx_ext < KEY_LENGTH);
   assign addr    = idx_ext[KAW-1:0];

   // key store with registered read
   always_ff @(posedge clock) begin
      if (accept && (req_cmd == CMD_KEY) && key_hit) begin
         key_mem[addr] <= val_ext[W-1:0];
      end
      if (accept) begin
         key_rd_ff <= key_mem[addr];
         key_ok_ff <= key_hit;
         val_ff    <= val_ext[W-1:0];
      end
   end

   // operand selection
   always_comb begin
      case (ctl.b_sel)
         BSEL_VAL:   b_src = val_ff;
         BSEL_KEY:   b_src = key_ok_ff ? key_rd_ff : '0;
         BSEL_INNER: b_src = inner_ff;
         default:    b_src = '0;
      endcase
      if (ctl.b_sel == BSEL_PLAIN) begin
         b_in = BW'(plain_modulus) << (BW - SCALE_BITS);
      end else begin
         b_in = BW'(b_src) << (BW - W);
      end
      diff = x_ff - r_ff + ((x_ff >= r_ff) ? '0 : q_w);
      case (ctl.a_sel)
         ASEL_ONE:  a_in = W'(1);
         ASEL_RES:  a_in = r_ff;
         ASEL_DIFF: a_in = diff;
         default:   a_in = '0;
      endcase
   end

   // one double-and-add step mod q, quotient bits counted for scaling
   always_comb begin
      bit_now = b_ff[BW-1];
      r2      = {r_ff, 1'b0};
      c1      = (r2 >= qx);
      r3      = c1 ? (r2 - qx) : r2;
      r4      = r3 + (bit_now ? {1'b0, a_ff} : '0);
      c2      = (r4 >= qx);
      r5      = c2 ? (r4 - qx) : r4;
      r_in    = r5[W-1:0];
      quo_in  = {quo_ff[QUO_W-2:0], 1'b0} + QUO_W'(c1) + QUO_W'(c2);
   end

   // accumulate and final rounding
   always_comb begin
      acc_sum  = {1'b0, r_ff} + {1'b0, x_ff};
      acc_mod  = (acc_sum >= qx) ? (acc_sum - qx) : acc_sum;
      inner_in = qsmall ? '0 : acc_mod[W-1:0];
      round_up = (r_ff >= (q_w - r_ff));
      quo_rnd  = quo_ff + QUO_W'(round_up);
      if (qsmall || (plain_modulus == 16'd0) || (quo_rnd >= {1'b0, plain_modulus})) begin
         msg_in = '0;
      end else begin
         msg_in = quo_rnd[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         r_ff   <= '0;
         quo_ff <= '0;
         a_ff   <= a_in;
         b_ff   <= b_in;
      end else if (ctl.step) begin
         r_ff   <= r_in;
         quo_ff <= quo_in;
         b_ff   <= b_ff << 1;
      end
      if (ctl.save_x) begin
         x_ff <= r_ff;
      end
      if (ctl.finish) begin
         msg_ff <= msg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff <= '0;
      end else if (ctl.acc_upd) begin
         inner_ff <= inner_in;
      end else if (ctl.finish) begin
         inner_ff <= '0;
      end
   end

   assign message = msg_ff;

endmodule

>>> hw/rtl/lwe_dec_ctrl.sv
// controller: sequences the step unit and owns the request and result handshakes
module lwe_dec_ctrl
   import lwe_dec_pkg::*;
#(
   parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic [1:0] req_cmd,
   input  logic       rsp_tready,
   output logic       req_tready,
   output logic       rsp_tvalid,
   output logic       accept,
   output dp_ctl_type ctl
);

   localparam int BW    = (MOD_WIDTH > SCALE_BITS) ? MOD_WIDTH : SCALE_BITS;
   localparam int CNT_W = $clog2(BW + 1);

   state_type        state_ff;
   state_type        state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             is_b_ff;
   logic             is_b_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             last_step;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign last_step  = (cnt_ff == CNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         is_b_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         is_b_ff      <= is_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      is_b_in     = is_b_ff;
      ctl         = '0;
      ctl.a_sel   = ASEL_ONE;
      ctl.b_sel   = BSEL_VAL;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == CMD_A || req_cmd == CMD_B)) begin
               is_b_in  = (req_cmd == CMD_B);
               state_in = ST_VAL_INIT;
            end
         end
         ST_VAL_INIT: begin
            ctl.start = 1'b1;
            ctl.a_sel = ASEL_ONE;
            ctl.b_sel = BSEL_VAL;
            cnt_in    = CNT_W'(MOD_WIDTH);
            state_in  = ST_VAL_RUN;
         end
         ST_VAL_RUN: begin
            ctl.step = 1'b1;
            cnt_in   = cnt_ff - CNT_W'(1);
            if (last_step) begin
               state_in = is_b_ff ? ST_INNER_INIT : ST_MUL_INIT;
            end
         end
         ST_MUL_INIT: begin
            ctl.start = 1'b1;
            ctl.a_sel = ASEL_RES;
            ctl.b_sel = BSEL_KEY;
            cnt_in    = CNT_W'(MOD_WIDTH);
            state_in  = ST_MUL_RUN;
         end
         ST_MUL_RUN: begin
            ctl.step = 1'b1;
            cnt_in   = cnt_ff - CNT_W'(1);
            if (last_step) begin
               state_in = ST_INNER_INIT;
            end
         end
         ST_INNER_INIT: begin
            ctl.save_x = 1'b1;
            ctl.start  = 1'b1;
            ctl.a_sel  = ASEL_ONE;
            ctl.b_sel  = BSEL_INNER;
            cnt_in     = CNT_W'(MOD_WIDTH);
            state_in   = ST_INNER_RUN;
         end
         ST_INNER_RUN: begin
            ctl.step = 1'b1;
            cnt_in   = cnt_ff - CNT_W'(1);
            if (last_step) begin
               state_in = is_b_ff ? ST_SCALE_INIT : ST_ACC;
            end
         end
         ST_ACC: begin
            ctl.acc_upd = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_SCALE_INIT: begin
            ctl.start = 1'b1;
            ctl.a_sel = ASEL_DIFF;
            ctl.b_sel = BSEL_PLAIN;
            cnt_in    = CNT_W'(SCALE_BITS);
            state_in  = ST_SCALE_RUN;
         end
         ST_SCALE_RUN: begin
            ctl.step = 1'b1;
            cnt_in   = cnt_ff - CNT_W'(1);
            if (last_step) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               ctl.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (ctl.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // result slot is free whenever a new message is loaded
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |-> (!rsp_valid_ff || rsp_tready))
      else $error("message loaded over a pending result");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result valid without finish");

   a_cnt_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VAL_RUN || state_ff == ST_MUL_RUN || state_ff == ST_INNER_RUN ||
       state_ff == ST_SCALE_RUN) |-> (cnt_ff != '0))
      else $error("step counter ran out");

   a_b_start: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_B) |=> (state_ff == ST_VAL_INIT && is_b_ff))
      else $error("b request not started");

endmodule
